FILE: rtl/priority_message_queue_defines.svh
// ---------------------------------------------------------------------------
// Priority message queue assertion macros
// Shared property templates for the queue's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_MESSAGE_QUEUE_DEFINES_SVH
`define PRIORITY_MESSAGE_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PMQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PMQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pmq_pkg.sv
// ---------------------------------------------------------------------------
// Priority message queue package
// Sizes, codes, slot record layout and the ordering rule used by the scan.
// ---------------------------------------------------------------------------
package pmq_pkg;

	// Storage geometry
	localparam int DEPTH         = 16;
	localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W         = $clog2(DEPTH + 1);
	localparam int PAYLOAD_BYTES = 8;

	// Fixed field widths
	localparam int PAYLOAD_W   = 64;
	localparam int BYTES_W     = 4;
	localparam int PRIO_W      = 8;
	localparam int SEQ_W       = 32;
	localparam int CFG_MAX_W   = 4;
	localparam int CFG_DEPTH_W = 5;
	localparam int CFG_DATA_W  = 5;
	localparam int DCMP_W      = (CNT_W > CFG_DEPTH_W) ? CNT_W : CFG_DEPTH_W;

	// Configuration register indexes
	localparam logic CFG_MAX_BYTES = 1'b0;
	localparam logic CFG_DEPTH     = 1'b1;

	// Operation kinds
	localparam logic KIND_SEND = 1'b0;
	localparam logic KIND_RECV = 1'b1;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_EMPTY    = 3'd2,
		STAT_SIZE     = 3'd3,
		STAT_CAPACITY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND_SCAN,
		ST_RECV_SCAN,
		ST_RECV_DRAIN,
		ST_RECV_DECIDE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [BYTES_W-1:0]   nbytes;
		logic [PRIO_W-1:0]    prio;
		logic [SEQ_W-1:0]     seq;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Candidate wins on higher priority, or on equal priority with an older
	// sequence number (wrap-aware: top bit of the difference)
	function automatic logic better(
		input logic [PRIO_W-1:0] cp,
		input logic [SEQ_W-1:0]  cs,
		input logic [PRIO_W-1:0] bp,
		input logic [SEQ_W-1:0]  bs
	);
		logic [SEQ_W-1:0] diff;
		diff = cs - bs;
		if (cp != bp) begin
			return cp > bp;
		end
		return diff[SEQ_W-1];
	endfunction

endpackage

FILE: rtl/pmq_ram.sv
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pmq_ram #(
	parameter int W_DATA  = 8,
	parameter int N_WORDS = 16
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [((N_WORDS > 1) ? $clog2(N_WORDS) : 1)-1:0] waddr,
	input  logic [W_DATA-1:0]     wdata,
	input  logic [((N_WORDS > 1) ? $clog2(N_WORDS) : 1)-1:0] raddr,
	output logic [W_DATA-1:0]     rdata
);

	logic [W_DATA-1:0] mem_q [N_WORDS];
	logic [W_DATA-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/priority_message_queue.sv
// A send goes from IDLE straight to RESULT on a size error, else it probes
// slots in SEND_SCAN; a receive passes RECV_SCAN, RECV_DRAIN and RECV_DECIDE.
// One operation at a time: the input stays stalled until the result is
// loaded into the output register.
// Reset clears all slot-full flags, counts, the sequence counter and restores
// max_message_bytes to 8 and depth_in_use to 16; slot records are not cleared.
// ---------------------------------------------------------------------------
// Priority message queue
// Fixed-depth message store with highest-priority, oldest-first dequeue,
// scanned one slot per cycle by a small sequencer.
// ---------------------------------------------------------------------------
module priority_message_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration writes
	input  logic                              cfg_wr_en,
	input  logic                              cfg_index,
	input  logic [pmq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// Operation channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [pmq_pkg::PAYLOAD_W-1:0]     payload,
	input  logic [pmq_pkg::BYTES_W-1:0]       payload_bytes,
	input  logic [pmq_pkg::PRIO_W-1:0]        priority_req,
	input  logic [pmq_pkg::BYTES_W-1:0]       receive_capacity,
	// Result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [pmq_pkg::PAYLOAD_W-1:0]     out_payload,
	output logic [pmq_pkg::BYTES_W-1:0]       out_bytes,
	output logic [pmq_pkg::PRIO_W-1:0]        out_priority,
	output logic [pmq_pkg::CNT_W-1:0]         messages_queued,
	output logic [pmq_pkg::CNT_W-1:0]         high_water_mark
);

`include "priority_message_queue_defines.svh"

	pmq_pkg::state_t                 state_q, state_d;

	// Configuration
	logic [pmq_pkg::CFG_MAX_W-1:0]   max_bytes_q;
	logic [pmq_pkg::CFG_DEPTH_W-1:0] depth_q;
	logic [pmq_pkg::BYTES_W-1:0]     size_lim;
	logic [pmq_pkg::DCMP_W-1:0]      depth_lim;

	// Queue bookkeeping
	logic [pmq_pkg::DEPTH-1:0]       slot_full_q;
	logic [pmq_pkg::CNT_W-1:0]       count_q;
	logic [pmq_pkg::CNT_W-1:0]       peak_q;
	logic [pmq_pkg::SEQ_W-1:0]       seq_q;

	// Latched operation
	logic                            kind_q;
	logic [pmq_pkg::PAYLOAD_W-1:0]   pay_q;
	logic [pmq_pkg::BYTES_W-1:0]     nbytes_q;
	logic [pmq_pkg::PRIO_W-1:0]      prio_q;
	logic [pmq_pkg::BYTES_W-1:0]     cap_q;
	logic [pmq_pkg::PAYLOAD_W-1:0]   pay_masked;

	// Scan
	logic [pmq_pkg::CNT_W-1:0]       scan_q;
	logic [pmq_pkg::IDX_W-1:0]       scan_idx;
	logic                            rd_vld_s1;
	logic [pmq_pkg::IDX_W-1:0]       rd_idx_s1;
	logic                            found_q;
	pmq_pkg::slot_t                  best_q;
	logic [pmq_pkg::IDX_W-1:0]       best_idx_q;
	pmq_pkg::slot_t                  rd_slot;
	pmq_pkg::slot_t                  wr_slot;
	logic                            cand_wins;

	// Sequencer strobes
	logic                            item_take;
	logic                            send_hit;
	logic                            scan_step;
	logic                            rd_issue;
	logic                            take_msg;
	logic                            out_load;
	logic                            res_ld;
	pmq_pkg::status_t                res_status_d, res_status_q;

	// Result register
	logic                            out_valid_q;
	pmq_pkg::status_t                out_status_q;
	logic [pmq_pkg::PAYLOAD_W-1:0]   out_payload_q;
	logic [pmq_pkg::BYTES_W-1:0]     out_bytes_q;
	logic [pmq_pkg::PRIO_W-1:0]      out_prio_q;
	logic [pmq_pkg::CNT_W-1:0]       out_count_q;
	logic [pmq_pkg::CNT_W-1:0]       out_peak_q;

	// Clamp configuration to the storage limits
	assign size_lim = (max_bytes_q > pmq_pkg::BYTES_W'(pmq_pkg::PAYLOAD_BYTES)) ?
		pmq_pkg::BYTES_W'(pmq_pkg::PAYLOAD_BYTES) : max_bytes_q;
	assign depth_lim = (pmq_pkg::DCMP_W'(depth_q) > pmq_pkg::DCMP_W'(pmq_pkg::DEPTH)) ?
		pmq_pkg::DCMP_W'(pmq_pkg::DEPTH) : pmq_pkg::DCMP_W'(depth_q);

	assign scan_idx = scan_q[pmq_pkg::IDX_W-1:0];

	// Keep only the low payload_bytes bytes of the payload
	always_comb begin
		for (int b = 0; b < pmq_pkg::PAYLOAD_W / 8; b++) begin
			pay_masked[b*8 +: 8] = (b < int'(payload_bytes)) ? payload[b*8 +: 8] : 8'd0;
		end
	end

	// Slot records
	assign wr_slot = '{payload: pay_q, nbytes: nbytes_q, prio: prio_q, seq: seq_q};

	pmq_ram #(
		.W_DATA  (pmq_pkg::SLOT_W),
		.N_WORDS (pmq_pkg::DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (send_hit),
		.waddr (scan_idx),
		.wdata (wr_slot),
		.raddr (scan_idx),
		.rdata (rd_slot)
	);

	assign cand_wins = !found_q ||
		pmq_pkg::better(rd_slot.prio, rd_slot.seq, best_q.prio, best_q.seq);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b1;
		item_take    = 1'b0;
		send_hit     = 1'b0;
		scan_step    = 1'b0;
		rd_issue     = 1'b0;
		take_msg     = 1'b0;
		out_load     = 1'b0;
		res_ld       = 1'b0;
		res_status_d = pmq_pkg::STAT_OK;
		case (state_q)
			pmq_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					item_take = 1'b1;
					if (kind == pmq_pkg::KIND_RECV) begin
						state_d = pmq_pkg::ST_RECV_SCAN;
					end else if (payload_bytes > size_lim) begin
						res_ld       = 1'b1;
						res_status_d = pmq_pkg::STAT_SIZE;
						state_d      = pmq_pkg::ST_RESULT;
					end else begin
						state_d = pmq_pkg::ST_SEND_SCAN;
					end
				end
			end
			pmq_pkg::ST_SEND_SCAN: begin
				if (pmq_pkg::DCMP_W'(scan_q) >= depth_lim) begin
					res_ld       = 1'b1;
					res_status_d = pmq_pkg::STAT_FULL;
					state_d      = pmq_pkg::ST_RESULT;
				end else if (!slot_full_q[scan_idx]) begin
					send_hit     = 1'b1;
					res_ld       = 1'b1;
					res_status_d = pmq_pkg::STAT_OK;
					state_d      = pmq_pkg::ST_RESULT;
				end else begin
					scan_step = 1'b1;
				end
			end
			pmq_pkg::ST_RECV_SCAN: begin
				rd_issue  = 1'b1;
				scan_step = 1'b1;
				if (scan_q == pmq_pkg::CNT_W'(pmq_pkg::DEPTH - 1)) begin
					state_d = pmq_pkg::ST_RECV_DRAIN;
				end
			end
			pmq_pkg::ST_RECV_DRAIN: begin
				state_d = pmq_pkg::ST_RECV_DECIDE;
			end
			pmq_pkg::ST_RECV_DECIDE: begin
				res_ld = 1'b1;
				if (!found_q) begin
					res_status_d = pmq_pkg::STAT_EMPTY;
				end else if (best_q.nbytes > cap_q) begin
					res_status_d = pmq_pkg::STAT_CAPACITY;
				end else begin
					res_status_d = pmq_pkg::STAT_OK;
					take_msg     = 1'b1;
				end
				state_d = pmq_pkg::ST_RESULT;
			end
			pmq_pkg::ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = pmq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pmq_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state: configuration, flags, counts, scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= pmq_pkg::CFG_MAX_W'(8);
			depth_q     <= pmq_pkg::CFG_DEPTH_W'(16);
			slot_full_q <= '0;
			count_q     <= '0;
			peak_q      <= '0;
			seq_q       <= '0;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Configuration writes
			if (cfg_wr_en) begin
				case (cfg_index)
					pmq_pkg::CFG_MAX_BYTES: max_bytes_q <= cfg_wdata[pmq_pkg::CFG_MAX_W-1:0];
					pmq_pkg::CFG_DEPTH:     depth_q     <= cfg_wdata[pmq_pkg::CFG_DEPTH_W-1:0];
					default: ;
				endcase
			end
			// Advance the scan
			if (item_take) begin
				scan_q <= '0;
			end else if (scan_step) begin
				scan_q <= scan_q + 1'b1;
			end
			rd_vld_s1 <= rd_issue && slot_full_q[scan_idx];
			// Track whether any queued slot has been seen
			if (item_take) begin
				found_q <= 1'b0;
			end else if (rd_vld_s1) begin
				found_q <= 1'b1;
			end
			// Claim a slot on send
			if (send_hit) begin
				slot_full_q[scan_idx] <= 1'b1;
				seq_q   <= seq_q + 1'b1;
				count_q <= count_q + 1'b1;
				if (count_q + 1'b1 > peak_q) begin
					peak_q <= count_q + 1'b1;
				end
			end
			// Release the chosen slot on receive
			if (take_msg) begin
				slot_full_q[best_idx_q] <= 1'b0;
				if (count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
			end
			// Result handshake
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: latched operation, best candidate, result
	always_ff @(posedge clk) begin
		if (item_take) begin
			kind_q   <= kind;
			pay_q    <= pay_masked;
			nbytes_q <= payload_bytes;
			prio_q   <= priority_req;
			cap_q    <= receive_capacity;
		end
		rd_idx_s1 <= scan_idx;
		// Hold the best queued slot seen so far
		if (rd_vld_s1 && cand_wins) begin
			best_q     <= rd_slot;
			best_idx_q <= rd_idx_s1;
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
			out_peak_q   <= peak_q;
			if (kind_q == pmq_pkg::KIND_RECV && res_status_q == pmq_pkg::STAT_OK) begin
				out_payload_q <= best_q.payload;
				out_bytes_q   <= best_q.nbytes;
				out_prio_q    <= best_q.prio;
			end else begin
				out_payload_q <= '0;
				out_bytes_q   <= '0;
				out_prio_q    <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign out_payload     = out_payload_q;
	assign out_bytes       = out_bytes_q;
	assign out_priority    = out_prio_q;
	assign messages_queued = out_count_q;
	assign high_water_mark = out_peak_q;

	// Checks
	`PMQ_ASSERT_IMP(a_count_matches_flags, 1'b1,
		$countones(slot_full_q) == int'(count_q), "message count disagrees with slot flags")
	`PMQ_ASSERT_IMP(a_peak_covers_count, 1'b1, peak_q >= count_q,
		"high-water mark below message count")
	`PMQ_ASSERT_NXT(a_busy_after_transfer, in_valid && !in_stall, in_stall,
		"operation accepted while previous one runs")
	`PMQ_ASSERT_IMP(a_take_only_queued, take_msg, slot_full_q[best_idx_q],
		"receive releases a free slot")

endmodule

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// Priority message queue testbench
// Sends and receives messages through the operation channel. The expected
// reply of each transfer comes from a slot-level model of the queue that
// tracks occupancy, sequence stamps, the size limit and the depth limit.
// A short directed table comes first. Random phases follow, each with its own
// register setting; where idling is on, random gaps and stalls hit both channels.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pmq_pkg::*;

	typedef struct packed {
		logic                 kind;
		logic [PAYLOAD_W-1:0] payload;
		logic [BYTES_W-1:0]   nbytes;
		logic [PRIO_W-1:0]    prio;
		logic [BYTES_W-1:0]   cap;
	} op_t;

	typedef struct packed {
		status_t              st;
		logic [PAYLOAD_W-1:0] payload;
		logic [BYTES_W-1:0]   nbytes;
		logic [PRIO_W-1:0]    prio;
		logic [CNT_W-1:0]     count;
		logic [CNT_W-1:0]     peak;
	} result_t;

	typedef enum logic {ROW_OP, ROW_REG} row_e;

	typedef struct {
		row_e                  what;
		op_t                   op;
		logic                  typed;
		result_t               want;
		logic                  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
	} step_t;

	localparam op_t     NO_OP   = '{KIND_SEND, 64'h0, 4'd0, 8'd0, 4'd0};
	localparam result_t NO_WANT = '{STAT_OK, 64'h0, 4'd0, 8'd0, 5'd0, 5'd0};
	localparam int      N_STEPS = 29;
	localparam int      N_PHASES = 10;
	localparam int      PHASE_OPS = 65;

	// DUT signals
	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_stall;
	logic                  kind;
	logic [PAYLOAD_W-1:0]  payload;
	logic [BYTES_W-1:0]    payload_bytes;
	logic [PRIO_W-1:0]     priority_req;
	logic [BYTES_W-1:0]    receive_capacity;
	logic                  out_valid;
	logic                  out_stall;
	logic [2:0]            status;
	logic [PAYLOAD_W-1:0]  out_payload;
	logic [BYTES_W-1:0]    out_bytes;
	logic [PRIO_W-1:0]     out_priority;
	logic [CNT_W-1:0]      messages_queued;
	logic [CNT_W-1:0]      high_water_mark;

	// Queue model state
	logic                  held_full    [DEPTH] = '{default: 1'b0};
	logic [PAYLOAD_W-1:0]  held_payload [DEPTH];
	logic [BYTES_W-1:0]    held_bytes   [DEPTH];
	logic [PRIO_W-1:0]     held_prio    [DEPTH];
	logic [SEQ_W-1:0]      held_seq     [DEPTH];
	logic [SEQ_W-1:0]      seq_next     = '0;
	logic [CNT_W-1:0]      held_count   = '0;
	logic [CNT_W-1:0]      held_peak    = '0;
	logic [CFG_MAX_W-1:0]  size_limit   = 4'd8;
	logic [CFG_DEPTH_W-1:0] depth_limit = 5'd16;

	result_t expected_replies [$];
	int      mismatches = 0;
	int      replies_checked = 0;
	int      status_hits [5] = '{default: 0};
	int      reg_writes = 0;
	bit      idle_en = 1'b0;

	// Directed table: typed replies where they follow directly from the rules
	step_t plan [N_STEPS] = '{
		// receive from an empty queue straight after reset
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd8}, 1'b1,
			'{STAT_EMPTY, 64'h0, 4'd0, 8'd0, 5'd0, 5'd0}, CFG_MAX_BYTES, 5'd0},
		// byte counts past the payload width
		'{ROW_OP, '{KIND_SEND, 64'h0, 4'd9, 8'd0, 4'd0}, 1'b1,
			'{STAT_SIZE, 64'h0, 4'd0, 8'd0, 5'd0, 5'd0}, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_SEND, {64{1'b1}}, 4'd15, 8'd255, 4'd15}, 1'b1,
			'{STAT_SIZE, 64'h0, 4'd0, 8'd0, 5'd0, 5'd0}, CFG_MAX_BYTES, 5'd0},
		// full-width, empty and partial messages
		'{ROW_OP, '{KIND_SEND, {64{1'b1}}, 4'd8, 8'd255, 4'd0}, 1'b1,
			'{STAT_OK, 64'h0, 4'd0, 8'd0, 5'd1, 5'd1}, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0, 8'd0, 4'd0}, 1'b1,
			'{STAT_OK, 64'h0, 4'd0, 8'd0, 5'd2, 5'd2}, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_SEND, 64'h1122_3344_5566_7788, 4'd3, 8'd255, 4'd0}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_SEND, 64'h0000_0000_0000_00C3, 4'd1, 8'd128, 4'd0}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		// capacity too small leaves the message queued
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd0}, 1'b1,
			'{STAT_CAPACITY, 64'h0, 4'd0, 8'd0, 5'd4, 5'd4}, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd8}, 1'b1,
			'{STAT_OK, {64{1'b1}}, 4'd8, 8'd255, 5'd3, 5'd4}, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd2}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd3}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd15}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd0}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd8}, 1'b1,
			'{STAT_EMPTY, 64'h0, 4'd0, 8'd0, 5'd0, 5'd4}, CFG_MAX_BYTES, 5'd0},
		// size limit of zero
		'{ROW_REG, NO_OP, 1'b0, NO_WANT, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 4'd1, 8'd1, 4'd0}, 1'b1,
			'{STAT_SIZE, 64'h0, 4'd0, 8'd0, 5'd0, 5'd4}, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_SEND, {64{1'b1}}, 4'd0, 8'd7, 4'd0}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		// depth of zero, then of one with the slot taken
		'{ROW_REG, NO_OP, 1'b0, NO_WANT, CFG_DEPTH, 5'd0},
		'{ROW_OP, '{KIND_SEND, 64'h0, 4'd0, 8'd9, 4'd0}, 1'b1,
			'{STAT_FULL, 64'h0, 4'd0, 8'd0, 5'd1, 5'd4}, CFG_MAX_BYTES, 5'd0},
		'{ROW_REG, NO_OP, 1'b0, NO_WANT, CFG_DEPTH, 5'd1},
		'{ROW_OP, '{KIND_SEND, 64'h0, 4'd0, 8'd9, 4'd0}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		// limits above the storage size saturate
		'{ROW_REG, NO_OP, 1'b0, NO_WANT, CFG_MAX_BYTES, 5'd15},
		'{ROW_REG, NO_OP, 1'b0, NO_WANT, CFG_DEPTH, 5'd31},
		'{ROW_OP, '{KIND_SEND, 64'h0123_4567_89AB_CDEF, 4'd8, 8'd7, 4'd0}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_SEND, 64'h0, 4'd9, 8'd7, 4'd0}, 1'b1,
			'{STAT_SIZE, 64'h0, 4'd0, 8'd0, 5'd2, 5'd4}, CFG_MAX_BYTES, 5'd0},
		// depth lowered below the held messages: they stay receivable
		'{ROW_REG, NO_OP, 1'b0, NO_WANT, CFG_DEPTH, 5'd2},
		'{ROW_OP, '{KIND_SEND, 64'hFFFF, 4'd2, 8'd200, 4'd0}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd8}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0},
		'{ROW_OP, '{KIND_RECV, 64'h0, 4'd0, 8'd0, 4'd8}, 1'b0,
			NO_WANT, CFG_MAX_BYTES, 5'd0}
	};

	// Random phases: register setting, share of sends, idling on or off
	int phase_max   [N_PHASES] = '{8, 1, 4, 8, 15, 16, 8, 5, 8, 8};
	int phase_depth [N_PHASES] = '{16, 1, 5, 16, 31, 16, 0, 3, 12, 16};
	int phase_sends [N_PHASES] = '{85, 60, 50, 90, 40, 70, 50, 55, 30, 50};
	bit phase_idle  [N_PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1, 1, 0};

	priority_message_queue uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.payload          (payload),
		.payload_bytes    (payload_bytes),
		.priority_req     (priority_req),
		.receive_capacity (receive_capacity),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.out_payload      (out_payload),
		.out_bytes        (out_bytes),
		.out_priority     (out_priority),
		.messages_queued  (messages_queued),
		.high_water_mark  (high_water_mark)
	);

	always #5 clk = ~clk;

	// Apply one operation to the queue model and return its reply
	function automatic result_t apply_queue_op(input op_t op);
		result_t     r;
		int unsigned lim;
		int unsigned dep;
		int unsigned pick;
		int          i;
		logic [SEQ_W-1:0] age;
		r = NO_WANT;
		if (op.kind == KIND_SEND) begin
			lim = (size_limit > PAYLOAD_BYTES) ? PAYLOAD_BYTES : size_limit;
			dep = (depth_limit > DEPTH) ? DEPTH : depth_limit;
			if (op.nbytes > lim) begin
				r.st = STAT_SIZE;
			end else begin
				r.st = STAT_FULL;
				// take the lowest free slot below the depth limit
				for (i = 0; i < dep; i++) begin
					if (r.st == STAT_FULL && !held_full[i]) begin
						held_full[i]    = 1'b1;
						held_payload[i] = (op.nbytes >= 8) ? op.payload :
							op.payload & ((64'h1 << (8 * op.nbytes)) - 64'h1);
						held_bytes[i]   = op.nbytes;
						held_prio[i]    = op.prio;
						held_seq[i]     = seq_next;
						seq_next        = seq_next + 1'b1;
						held_count      = held_count + 1'b1;
						if (held_count > held_peak) begin
							held_peak = held_count;
						end
						r.st = STAT_OK;
					end
				end
			end
		end else begin
			// highest priority wins, ties go to the older stamp
			pick = DEPTH;
			for (i = 0; i < DEPTH; i++) begin
				if (held_full[i]) begin
					if (pick == DEPTH) begin
						pick = i;
					end else begin
						age = held_seq[i] - held_seq[pick];
						if (held_prio[i] > held_prio[pick] ||
							(held_prio[i] == held_prio[pick] && age[SEQ_W-1])) begin
							pick = i;
						end
					end
				end
			end
			if (pick == DEPTH) begin
				r.st = STAT_EMPTY;
			end else if (held_bytes[pick] > op.cap) begin
				r.st = STAT_CAPACITY;
			end else begin
				r.payload       = held_payload[pick];
				r.nbytes        = held_bytes[pick];
				r.prio          = held_prio[pick];
				held_full[pick] = 1'b0;
				if (held_count > 0) begin
					held_count = held_count - 1'b1;
				end
			end
		end
		r.count = held_count;
		r.peak  = held_peak;
		return r;
	endfunction

	// Present one operation and hold it until the transfer
	task automatic issue_op(input op_t op, input logic typed, input result_t want);
		result_t r;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid         <= 1'b1;
		kind             <= op.kind;
		payload          <= op.payload;
		payload_bytes    <= op.nbytes;
		priority_req     <= op.prio;
		receive_capacity <= op.cap;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = apply_queue_op(op);
		expected_replies.push_back(typed ? want : r);
	endtask

	// Stop sending and wait until every reply is back
	task automatic finish_outstanding();
		in_valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == CFG_MAX_BYTES) begin
			size_limit = val[CFG_MAX_W-1:0];
		end else begin
			depth_limit = val;
		end
		reg_writes++;
	endtask

	// Result side back-pressure in random bursts
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (idle_en && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Compare each reply transfer with the oldest expectation
	always @(posedge clk) begin : check_replies
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] reply with nothing expected: status %0d", $realtime, status);
				end
			end else begin
				want = expected_replies.pop_front();
				replies_checked++;
				status_hits[int'(want.st)]++;
				if (status !== want.st || out_payload !== want.payload ||
					out_bytes !== want.nbytes || out_priority !== want.prio ||
					messages_queued !== want.count || high_water_mark !== want.peak) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("[%0t] reply mismatch: exp st %0d pay %h n %0d pr %0d q %0d hw %0d",
							$realtime, want.st, want.payload, want.nbytes, want.prio,
							want.count, want.peak);
						$display("[%0t]                 got st %0d pay %h n %0d pr %0d q %0d hw %0d",
							$realtime, status, out_payload, out_bytes, out_priority,
							messages_queued, high_water_mark);
					end
				end
			end
		end
	end

	// Main sequence
	initial begin
		op_t         op;
		int          p;
		int          n;
		int unsigned lim;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = CFG_MAX_BYTES;
		cfg_wdata        = '0;
		in_valid         = 1'b0;
		kind             = KIND_SEND;
		payload          = '0;
		payload_bytes    = '0;
		priority_req     = '0;
		receive_capacity = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table without idling
		foreach (plan[k]) begin
			if (plan[k].what == ROW_REG) begin
				finish_outstanding();
				write_reg(plan[k].reg_idx, plan[k].reg_val);
			end else begin
				issue_op(plan[k].op, plan[k].typed, plan[k].want);
			end
		end

		// random phases; messages carry over from one setting to the next
		for (p = 0; p < N_PHASES; p++) begin
			finish_outstanding();
			idle_en = phase_idle[p];
			write_reg(CFG_MAX_BYTES, CFG_DATA_W'(phase_max[p]));
			write_reg(CFG_DEPTH, CFG_DATA_W'(phase_depth[p]));
			lim = (size_limit > PAYLOAD_BYTES) ? PAYLOAD_BYTES : size_limit;
			for (n = 0; n < PHASE_OPS; n++) begin
				op.kind    = ($urandom_range(0, 99) < phase_sends[p]) ? KIND_SEND : KIND_RECV;
				op.payload = {$urandom(), $urandom()};
				op.nbytes  = ($urandom_range(0, 4) == 0) ? BYTES_W'($urandom_range(0, 15)) :
					BYTES_W'($urandom_range(0, lim));
				op.prio    = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3)) :
					PRIO_W'($urandom_range(0, 255));
				op.cap     = $urandom_range(0, 2) ? BYTES_W'(PAYLOAD_BYTES) :
					BYTES_W'($urandom_range(0, 15));
				issue_op(op, 1'b0, NO_WANT);
			end
		end

		// drain and let the sequencer settle
		in_valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("%0d replies checked over %0d register writes, peak occupancy %0d",
			replies_checked, reg_writes, held_peak);
		$display("ok %0d, full %0d, empty %0d, size %0d, capacity %0d, mismatches %0d",
			status_hits[STAT_OK], status_hits[STAT_FULL], status_hits[STAT_EMPTY],
			status_hits[STAT_SIZE], status_hits[STAT_CAPACITY], mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("timeout with %0d replies outstanding", expected_replies.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pmq_pkg.sv
rtl/pmq_ram.sv
rtl/priority_message_queue.sv
verif/tb_top.sv
